// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; each use expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: %m");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition: %m");

`endif

// ===== sv/lcdsb_pkg.sv =====
package lcdsb_pkg;

  typedef struct packed {
    logic [3:0] command;
    logic [3:0] index;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       last;
    logic       blink_phase;
    logic [1:0] fan_cursor_slow;
    logic [1:0] fan_cursor_medium;
    logic [1:0] fan_cursor_fast;
  } res_t;

  localparam logic [3:0] CMD_DIGIT     = 4'd0;
  localparam logic [3:0] CMD_PAIR      = 4'd1;
  localparam logic [3:0] CMD_CLR_PAIR  = 4'd2;
  localparam logic [3:0] CMD_SPEED     = 4'd3;
  localparam logic [3:0] CMD_ICON_ON   = 4'd4;
  localparam logic [3:0] CMD_ICON_OFF  = 4'd5;
  localparam logic [3:0] CMD_TOGGLE    = 4'd6;
  localparam logic [3:0] CMD_FAN       = 4'd7;
  localparam logic [3:0] CMD_CLR_FAN   = 4'd8;
  localparam logic [3:0] CMD_ROTATE    = 4'd9;
  localparam logic [3:0] CMD_CLEAR     = 4'd10;
  localparam logic [3:0] CMD_SET       = 4'd11;
  localparam logic [3:0] CMD_TICK      = 4'd12;
  localparam logic [3:0] CMD_FLUSH     = 4'd13;

  localparam logic [3:0] ICON_CLOCK  = 4'd0;
  localparam logic [3:0] ICON_FAN1   = 4'd1;
  localparam logic [3:0] ICON_COLON1 = 4'd2;
  localparam logic [3:0] ICON_FAN2   = 4'd3;
  localparam logic [3:0] ICON_COLON2 = 4'd4;
  localparam logic [3:0] ICON_LIGHT  = 4'd5;
  localparam logic [3:0] ICON_FAN3   = 4'd6;

  localparam logic       MODE_WHITE = 1'b0;

  localparam logic [7:0] BIT3 = 8'h08;
  localparam logic [7:0] BIT4 = 8'h10;
  localparam logic [7:0] BIT7 = 8'h80;

  localparam logic [7:0] FLUSH_CMD0 = 8'h40;
  localparam logic [7:0] FLUSH_CMD1 = 8'hC2;

  localparam logic [3:0] FIRST_BYTE = 4'd2;
  localparam logic [3:0] LAST_BYTE  = 4'd14;
  localparam logic [3:0] FILL_OPS   = 4'd13;

  localparam logic [3:0] BLANK_GLYPH = 4'd10;
  localparam logic [3:0] F_GLYPH     = 4'd11;

  localparam logic [7:0] GLYPH_A [12] = '{8'hAF, 8'h06, 8'h6D, 8'h4F, 8'hC6, 8'hCB,
                                          8'hEB, 8'h0E, 8'hEF, 8'hCF, 8'h00, 8'hE8};
  localparam logic [7:0] GLYPH_B [12] = '{8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3,
                                          8'hD7, 8'h70, 8'hF7, 8'hF3, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_C [12] = '{8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D,
                                          8'h7D, 8'h07, 8'h7F, 8'h3F, 8'h00, 8'h00};
  localparam logic [7:0] GLYPH_D [12] = '{8'hFA, 8'h60, 8'hD6, 8'hF4, 8'h6C, 8'hBC,
                                          8'hBE, 8'hE0, 8'hFE, 8'hFC, 8'h00, 8'h8E};

  localparam logic [3:0] WHITE_PLACE [9] = '{4'd10, 4'd9, 4'd5, 4'd4, 4'd12, 4'd11,
                                             4'd2, 4'd3, 4'd14};
  localparam logic [3:0] BLACK_PLACE [4] = '{4'd7, 4'd6, 4'd3, 4'd11};

endpackage

// ===== sv/lcd_segment_buffer_controller_core.sv =====
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------
// request   | in        | start && !busy         | req_i (command, index, value)
// result    | out       | res_strobe_o, 1 cycle  | res_o (byte, flags, cursors)
// config    | in        | cfg_we_i               | cfg_wdata_i (working mode)
//
// Buffer updates run read then write on the 16-byte buffer RAM: each touched
// byte takes a read state and then a write state, and a done state gives the
// status result; tick and unused commands go straight to the done state. Flush
// streams one byte per cycle. The result shows in the cycle after the last busy
// cycle; reset clears the buffer through per-byte valid flags at once, with no
// clearing pass. No stalls.
`include "assert_macros.svh"

module lcd_segment_buffer_controller_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lcdsb_pkg::req_t   req_i,
  output logic              res_strobe_o,
  output lcdsb_pkg::res_t   res_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       vld;
    logic [3:0] addr;
    logic [7:0] keep;
    logic [7:0] set;
    logic [7:0] flip;
  } op_t;

  state_e          state_q;
  lcdsb_pkg::req_t req_q;
  logic [3:0]      cnt_q;
  logic            mode_q;
  lcdsb_pkg::res_t res_q;
  logic            res_vld_q;

  logic [3:0]      blink_cnt_q, blink_cnt_d;
  logic            blink_flag_q, blink_flag_d;
  logic            fast_div_q, fast_div_d;
  logic [1:0]      med_div_q, med_div_d;
  logic [2:0]      slow_div_q, slow_div_d;
  logic [1:0]      cur_q [3];
  logic [1:0]      cur_d [3];

  logic [7:0]      seg_mem [16];
  logic [15:0]     vld_q;
  logic [7:0]      rd_data_q;
  logic            rd_vld_q;
  logic [7:0]      rd_byte;
  logic [3:0]      raddr;
  logic            mem_we;
  logic [7:0]      wdata;

  logic            accept;
  logic            tick_en;
  op_t             op;
  logic [3:0]      n_ops_cur;
  logic [15:0]     quot_prod;
  logic [3:0]      tens;
  logic [3:0]      ones;
  logic [7:0]      fan_num;
  logic [3:0]      digit_g;
  logic [3:0]      speed_g;

  function automatic logic [3:0] n_ops(input logic [3:0] cmd);
    logic [3:0] n;
    case (cmd)
      lcdsb_pkg::CMD_DIGIT:    n = 4'd1;
      lcdsb_pkg::CMD_PAIR:     n = 4'd2;
      lcdsb_pkg::CMD_CLR_PAIR: n = 4'd2;
      lcdsb_pkg::CMD_SPEED:    n = 4'd4;
      lcdsb_pkg::CMD_ICON_ON:  n = 4'd2;
      lcdsb_pkg::CMD_ICON_OFF: n = 4'd2;
      lcdsb_pkg::CMD_TOGGLE:   n = 4'd1;
      lcdsb_pkg::CMD_FAN:      n = 4'd3;
      lcdsb_pkg::CMD_CLR_FAN:  n = 4'd3;
      lcdsb_pkg::CMD_ROTATE:   n = 4'd3;
      lcdsb_pkg::CMD_CLEAR:    n = lcdsb_pkg::FILL_OPS;
      lcdsb_pkg::CMD_SET:      n = lcdsb_pkg::FILL_OPS;
      default:                 n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic op_t digit_op(input logic [3:0] pos, input logic [3:0] g,
                                   input logic mode);
    op_t o;
    o = '0;
    if (pos <= 4'd3) begin
      o.vld = 1'b1;
      if (mode == lcdsb_pkg::MODE_WHITE) begin
        o.addr = lcdsb_pkg::WHITE_PLACE[pos];
        o.keep = lcdsb_pkg::BIT4;
        o.set  = lcdsb_pkg::GLYPH_A[g];
      end else if (pos == 4'd3) begin
        o.addr = lcdsb_pkg::BLACK_PLACE[2'd3];
        o.set  = lcdsb_pkg::GLYPH_D[g];
      end else begin
        o.addr = lcdsb_pkg::BLACK_PLACE[pos[1:0]];
        o.keep = lcdsb_pkg::BIT4;
        o.set  = lcdsb_pkg::GLYPH_A[g];
      end
    end else if (pos == 4'd4 || pos == 4'd5 || pos == 4'd8) begin
      o.vld  = 1'b1;
      o.addr = lcdsb_pkg::WHITE_PLACE[pos];
      o.keep = lcdsb_pkg::BIT7;
      o.set  = lcdsb_pkg::GLYPH_C[g];
    end else if (pos == 4'd6 || pos == 4'd7) begin
      o.vld  = 1'b1;
      o.addr = lcdsb_pkg::WHITE_PLACE[pos];
      o.keep = lcdsb_pkg::BIT3;
      o.set  = lcdsb_pkg::GLYPH_B[g];
    end
    return o;
  endfunction

  function automatic op_t bit_op(input logic [3:0] addr, input logic [7:0] mask,
                                 input logic on);
    op_t o;
    o      = '0;
    o.vld  = 1'b1;
    o.addr = addr;
    o.keep = ~mask;
    o.set  = on ? mask : 8'h00;
    return o;
  endfunction

  function automatic op_t flip_op(input logic [3:0] addr, input logic [7:0] mask);
    op_t o;
    o      = '0;
    o.vld  = 1'b1;
    o.addr = addr;
    o.keep = 8'hFF;
    o.flip = mask;
    return o;
  endfunction

  function automatic logic [1:0] advance(input logic [1:0] c);
    return (c >= 2'd2) ? 2'd0 : 2'(c + 2'd1);
  endfunction

  assign accept    = start && !busy;
  assign tick_en   = accept && (req_i.command == lcdsb_pkg::CMD_TICK);
  assign busy      = (state_q != ST_IDLE);
  assign n_ops_cur = n_ops(req_q.command);

  // Split a pair value below 100 into tens and ones by reciprocal multiply.
  assign quot_prod = {8'd0, req_q.value} * 16'd205;
  assign tens      = quot_prod[14:11];
  assign ones      = 4'(req_q.value - 8'({4'd0, tens} * 8'd10));
  assign digit_g   = (req_q.value < 8'd10) ? req_q.value[3:0] : lcdsb_pkg::BLANK_GLYPH;
  assign speed_g   = digit_g;

  always_comb begin
    case (req_q.command)
      lcdsb_pkg::CMD_FAN:    fan_num = req_q.value;
      lcdsb_pkg::CMD_ROTATE: begin
        if (req_q.value == 8'd0) begin
          fan_num = 8'd8;
        end else if (req_q.value == 8'd1) begin
          fan_num = {6'd0, cur_q[0]};
        end else if (req_q.value <= 8'd3) begin
          fan_num = {6'd0, cur_q[1]};
        end else begin
          fan_num = {6'd0, cur_q[2]};
        end
      end
      default:               fan_num = 8'd8;
    endcase
  end

  // Build the read-modify-write for step cnt_q of the current request.
  always_comb begin
    op = '0;
    case (req_q.command)
      lcdsb_pkg::CMD_DIGIT: begin
        op = digit_op(req_q.index, digit_g, mode_q);
      end
      lcdsb_pkg::CMD_PAIR: begin
        if (req_q.index <= 4'd3 && req_q.value < 8'd100) begin
          op = digit_op({1'b0, req_q.index[1:0], cnt_q[0]}, cnt_q[0] ? ones : tens,
                        mode_q);
        end
      end
      lcdsb_pkg::CMD_CLR_PAIR: begin
        if (req_q.index <= 4'd3) begin
          op = digit_op({1'b0, req_q.index[1:0], cnt_q[0]}, lcdsb_pkg::BLANK_GLYPH,
                        mode_q);
        end
      end
      lcdsb_pkg::CMD_SPEED: begin
        if (mode_q == lcdsb_pkg::MODE_WHITE) begin
          if (cnt_q == 4'd0) begin
            op = digit_op(4'd8, speed_g, mode_q);
          end
        end else if (req_q.value < 8'd10) begin
          op.vld = 1'b1;
          case (cnt_q)
            4'd0: begin
              op.addr = lcdsb_pkg::BLACK_PLACE[2'd0];
              op.keep = lcdsb_pkg::BIT4;
            end
            4'd1: begin
              op.addr = lcdsb_pkg::BLACK_PLACE[2'd1];
              op.keep = lcdsb_pkg::BIT4;
              op.set  = lcdsb_pkg::GLYPH_A[lcdsb_pkg::F_GLYPH];
            end
            4'd2: begin
              // the colon bit of this byte ends up cleared
              op.addr = lcdsb_pkg::BLACK_PLACE[2'd2];
              op.set  = lcdsb_pkg::GLYPH_A[req_q.value[3:0]] & ~lcdsb_pkg::BIT4;
            end
            default: begin
              op.addr = lcdsb_pkg::BLACK_PLACE[2'd3];
            end
          endcase
        end
      end
      lcdsb_pkg::CMD_ICON_ON, lcdsb_pkg::CMD_ICON_OFF: begin
        if (cnt_q == 4'd0) begin
          case (req_q.index)
            lcdsb_pkg::ICON_CLOCK: begin
              if (mode_q == lcdsb_pkg::MODE_WHITE) begin
                op = bit_op(4'd10, lcdsb_pkg::BIT4,
                            req_q.command == lcdsb_pkg::CMD_ICON_ON);
              end else begin
                op = bit_op(4'd2, 8'hFF, 1'b0);
                op.set = {7'd0, req_q.command == lcdsb_pkg::CMD_ICON_ON};
              end
            end
            lcdsb_pkg::ICON_FAN1:
              op = bit_op(4'd9, lcdsb_pkg::BIT4, req_q.command == lcdsb_pkg::CMD_ICON_ON);
            lcdsb_pkg::ICON_COLON1:
              op = bit_op((mode_q == lcdsb_pkg::MODE_WHITE) ? 4'd5 : 4'd3, lcdsb_pkg::BIT4,
                          req_q.command == lcdsb_pkg::CMD_ICON_ON);
            lcdsb_pkg::ICON_FAN2:
              op = bit_op(4'd4, lcdsb_pkg::BIT4, req_q.command == lcdsb_pkg::CMD_ICON_ON);
            lcdsb_pkg::ICON_COLON2:
              op = bit_op(4'd2, lcdsb_pkg::BIT3, req_q.command == lcdsb_pkg::CMD_ICON_ON);
            lcdsb_pkg::ICON_LIGHT: begin
              if (mode_q == lcdsb_pkg::MODE_WHITE) begin
                op = bit_op(4'd12, lcdsb_pkg::BIT7,
                            req_q.command == lcdsb_pkg::CMD_ICON_ON);
              end else begin
                op = bit_op(4'd6, lcdsb_pkg::BIT4,
                            req_q.command == lcdsb_pkg::CMD_ICON_ON);
              end
            end
            lcdsb_pkg::ICON_FAN3:
              op = bit_op(4'd14, lcdsb_pkg::BIT7, req_q.command == lcdsb_pkg::CMD_ICON_ON);
            default: op = '0;
          endcase
        end else if (req_q.index == lcdsb_pkg::ICON_LIGHT &&
                     mode_q != lcdsb_pkg::MODE_WHITE) begin
          // black panel light spans two bytes
          op = bit_op(4'd7, lcdsb_pkg::BIT4, req_q.command == lcdsb_pkg::CMD_ICON_ON);
        end
      end
      lcdsb_pkg::CMD_TOGGLE: begin
        case (req_q.index)
          lcdsb_pkg::ICON_CLOCK:  op = flip_op(4'd10, lcdsb_pkg::BIT4);
          lcdsb_pkg::ICON_FAN1:   op = flip_op(4'd9, lcdsb_pkg::BIT4);
          lcdsb_pkg::ICON_COLON1: op = flip_op(4'd5, lcdsb_pkg::BIT4);
          lcdsb_pkg::ICON_FAN2:   op = flip_op(4'd4, lcdsb_pkg::BIT4);
          lcdsb_pkg::ICON_COLON2: op = flip_op(4'd2, lcdsb_pkg::BIT3);
          lcdsb_pkg::ICON_LIGHT:  op = flip_op(4'd12, lcdsb_pkg::BIT7);
          lcdsb_pkg::ICON_FAN3:   op = flip_op(4'd14, lcdsb_pkg::BIT7);
          default:                op = '0;
        endcase
      end
      lcdsb_pkg::CMD_FAN, lcdsb_pkg::CMD_CLR_FAN, lcdsb_pkg::CMD_ROTATE: begin
        if (mode_q == lcdsb_pkg::MODE_WHITE) begin
          case (cnt_q)
            4'd0:    op = bit_op(4'd9, lcdsb_pkg::BIT4, fan_num == 8'd0);
            4'd1:    op = bit_op(4'd4, lcdsb_pkg::BIT4, fan_num == 8'd1);
            default: op = bit_op(4'd14, lcdsb_pkg::BIT7, fan_num == 8'd2);
          endcase
        end else if (cnt_q == 4'd0) begin
          op = bit_op(4'd14, 8'hFF, 1'b0);
          op.set = (fan_num < 8'd7) ? 8'(8'd2 << fan_num[2:0]) : 8'h00;
        end
      end
      lcdsb_pkg::CMD_CLEAR, lcdsb_pkg::CMD_SET: begin
        op.vld  = 1'b1;
        op.addr = 4'(cnt_q + lcdsb_pkg::FIRST_BYTE);
        op.set  = (req_q.command == lcdsb_pkg::CMD_SET) ? 8'hFF : 8'h00;
      end
      default: op = '0;
    endcase
  end

  // Buffer RAM: one read and one write port, registered read data.
  assign raddr   = (state_q == ST_FLUSH) ? 4'(cnt_q + 4'd1) : op.addr;
  assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;
  assign mem_we  = (state_q == ST_WR) && op.vld;
  assign wdata   = ((rd_byte & op.keep) | op.set) ^ op.flip;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[op.addr] <= wdata;
    end
    rd_data_q <= seg_mem[raddr];
  end

  // Bytes never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[op.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr];
    end
  end

  always_comb begin
    logic [3:0] bc_inc;
    logic [2:0] slow_inc;
    logic [1:0] med_inc;
    bc_inc       = 4'(blink_cnt_q + 4'd1);
    blink_cnt_d  = (bc_inc >= 4'd10) ? 4'd0 : bc_inc;
    blink_flag_d = (blink_cnt_d >= 4'd3);
    cur_d        = cur_q;
    fast_div_d   = ~fast_div_q;
    if (fast_div_q) begin
      cur_d[2] = advance(cur_q[2]);
    end
    slow_inc   = 3'(slow_div_q + 3'd1);
    slow_div_d = slow_inc;
    if (slow_inc >= 3'd5) begin
      slow_div_d = 3'd0;
      cur_d[0]   = advance(cur_q[0]);
    end
    med_inc   = 2'(med_div_q + 2'd1);
    med_div_d = med_inc;
    if (med_inc >= 2'd3) begin
      med_div_d = 2'd0;
      cur_d[1]  = advance(cur_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      blink_cnt_q  <= '0;
      blink_flag_q <= 1'b0;
      fast_div_q   <= 1'b0;
      med_div_q    <= '0;
      slow_div_q   <= '0;
      cur_q        <= '{default: 2'd0};
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (tick_en) begin
        blink_cnt_q  <= blink_cnt_d;
        blink_flag_q <= blink_flag_d;
        fast_div_q   <= fast_div_d;
        med_div_q    <= med_div_d;
        slow_div_q   <= slow_div_d;
        cur_q        <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
      req_q     <= '0;
      res_q     <= '0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            cnt_q <= '0;
            if (req_i.command == lcdsb_pkg::CMD_FLUSH) begin
              state_q <= ST_FLUSH;
            end else if (n_ops(req_i.command) != 4'd0) begin
              state_q <= ST_RD;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_WR;
        end
        ST_WR: begin
          if (cnt_q == 4'(n_ops_cur - 4'd1)) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= 4'(cnt_q + 4'd1);
            state_q <= ST_RD;
          end
        end
        ST_FLUSH: begin
          res_vld_q               <= 1'b1;
          res_q.frame_start       <= (cnt_q < lcdsb_pkg::FIRST_BYTE);
          res_q.last              <= (cnt_q == lcdsb_pkg::LAST_BYTE);
          res_q.blink_phase       <= blink_flag_q;
          res_q.fan_cursor_slow   <= cur_q[0];
          res_q.fan_cursor_medium <= cur_q[1];
          res_q.fan_cursor_fast   <= cur_q[2];
          if (cnt_q == 4'd0) begin
            res_q.data_byte <= lcdsb_pkg::FLUSH_CMD0;
          end else if (cnt_q == 4'd1) begin
            res_q.data_byte <= lcdsb_pkg::FLUSH_CMD1;
          end else begin
            res_q.data_byte <= rd_byte;
          end
          if (cnt_q == lcdsb_pkg::LAST_BYTE) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= 4'(cnt_q + 4'd1);
          end
        end
        ST_DONE: begin
          res_vld_q               <= 1'b1;
          res_q.data_byte         <= 8'h00;
          res_q.frame_start       <= 1'b0;
          res_q.last              <= 1'b1;
          res_q.blink_phase       <= blink_flag_q;
          res_q.fan_cursor_slow   <= cur_q[0];
          res_q.fan_cursor_medium <= cur_q[1];
          res_q.fan_cursor_fast   <= cur_q[2];
          state_q                 <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_strobe_o = res_vld_q;
  assign res_o        = res_q;

  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy)
  `ASSERT_CLK(a_last_gap, (res_strobe_o && res_o.last) |=> !res_strobe_o)
  `ASSERT_NEVER(a_frame_last, res_strobe_o && res_o.frame_start && res_o.last)
  `ASSERT_NEVER(a_flush_cnt, (state_q == ST_FLUSH) && (cnt_q > lcdsb_pkg::LAST_BYTE))
  `ASSERT_NEVER(a_op_cnt, (state_q == ST_WR) && (cnt_q >= n_ops_cur))

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_PER_PHASE = 73;
  localparam logic MODE_BLACK = ~lcdsb_pkg::MODE_WHITE;
  localparam logic [3:0] CMD_UNUSED = 4'd15;
  localparam logic [3:0] IDX_MAX = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  lcdsb_pkg::req_t req_i = '0;
  logic res_strobe_o;
  lcdsb_pkg::res_t res_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  lcd_segment_buffer_controller_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow of the panel state
  logic       panel_mode = lcdsb_pkg::MODE_WHITE;
  logic [7:0] lcd_buf [16];
  logic [3:0] blink_cnt;
  logic       blink_on;
  logic       div2;
  logic [1:0] div3;
  logic [2:0] div5;
  logic [1:0] cur_slow, cur_med, cur_fast;

  lcdsb_pkg::res_t lcd_out_q [$];
  int unsigned err_count = 0;
  int unsigned cycles_run = 0;
  int unsigned gap_pct = 0;

  typedef struct {
    logic            mode;
    lcdsb_pkg::req_t r;
    bit              typed;
    lcdsb_pkg::res_t want;
  } step_t;
  step_t steps [$];

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic void draw_digit(int unsigned pos, int unsigned num);
    int unsigned g;
    int unsigned p;
    g = (num < 10) ? num : lcdsb_pkg::BLANK_GLYPH;
    if (pos <= 3) begin
      if (panel_mode == lcdsb_pkg::MODE_WHITE) begin
        p = lcdsb_pkg::WHITE_PLACE[pos];
        lcd_buf[p] = lcdsb_pkg::GLYPH_A[g] | (lcd_buf[p] & lcdsb_pkg::BIT4);
      end else if (pos == 3) begin
        lcd_buf[lcdsb_pkg::BLACK_PLACE[3]] = lcdsb_pkg::GLYPH_D[g];
      end else begin
        p = lcdsb_pkg::BLACK_PLACE[pos];
        lcd_buf[p] = lcdsb_pkg::GLYPH_A[g] | (lcd_buf[p] & lcdsb_pkg::BIT4);
      end
    end else if (pos == 4 || pos == 5 || pos == 8) begin
      p = lcdsb_pkg::WHITE_PLACE[pos];
      lcd_buf[p] = lcdsb_pkg::GLYPH_C[g] | (lcd_buf[p] & lcdsb_pkg::BIT7);
    end else if (pos == 6 || pos == 7) begin
      p = lcdsb_pkg::WHITE_PLACE[pos];
      lcd_buf[p] = lcdsb_pkg::GLYPH_B[g] | (lcd_buf[p] & lcdsb_pkg::BIT3);
    end
  endfunction

  function automatic void set_icon(logic [3:0] icon, bit on);
    int unsigned p;
    logic [7:0] m;
    m = '0;
    p = 0;
    case (icon)
      lcdsb_pkg::ICON_CLOCK: begin
        if (panel_mode == lcdsb_pkg::MODE_WHITE) begin
          p = 10; m = lcdsb_pkg::BIT4;
        end else begin
          lcd_buf[2] = on ? 8'h01 : 8'h00;
        end
      end
      lcdsb_pkg::ICON_FAN1: begin p = 9; m = lcdsb_pkg::BIT4; end
      lcdsb_pkg::ICON_COLON1: begin
        p = (panel_mode == lcdsb_pkg::MODE_WHITE) ? 5 : 3; m = lcdsb_pkg::BIT4;
      end
      lcdsb_pkg::ICON_FAN2: begin p = 4; m = lcdsb_pkg::BIT4; end
      lcdsb_pkg::ICON_COLON2: begin p = 2; m = lcdsb_pkg::BIT3; end
      lcdsb_pkg::ICON_LIGHT: begin
        if (panel_mode == lcdsb_pkg::MODE_WHITE) begin
          p = 12; m = lcdsb_pkg::BIT7;
        end else if (on) begin
          lcd_buf[6] |= lcdsb_pkg::BIT4;
          lcd_buf[7] |= lcdsb_pkg::BIT4;
        end else begin
          lcd_buf[6] &= ~lcdsb_pkg::BIT4;
          lcd_buf[7] &= ~lcdsb_pkg::BIT4;
        end
      end
      lcdsb_pkg::ICON_FAN3: begin p = 14; m = lcdsb_pkg::BIT7; end
      default: ;
    endcase
    if (m != '0) lcd_buf[p] = on ? (lcd_buf[p] | m) : (lcd_buf[p] & ~m);
  endfunction

  // Toggle keeps the white-panel bit positions in both modes
  function automatic void flip_icon(logic [3:0] icon);
    case (icon)
      lcdsb_pkg::ICON_CLOCK:  lcd_buf[10] ^= lcdsb_pkg::BIT4;
      lcdsb_pkg::ICON_FAN1:   lcd_buf[9] ^= lcdsb_pkg::BIT4;
      lcdsb_pkg::ICON_COLON1: lcd_buf[5] ^= lcdsb_pkg::BIT4;
      lcdsb_pkg::ICON_FAN2:   lcd_buf[4] ^= lcdsb_pkg::BIT4;
      lcdsb_pkg::ICON_COLON2: lcd_buf[2] ^= lcdsb_pkg::BIT3;
      lcdsb_pkg::ICON_LIGHT:  lcd_buf[12] ^= lcdsb_pkg::BIT7;
      lcdsb_pkg::ICON_FAN3:   lcd_buf[14] ^= lcdsb_pkg::BIT7;
      default: ;
    endcase
  endfunction

  function automatic void draw_fan(int unsigned n);
    if (panel_mode == lcdsb_pkg::MODE_WHITE) begin
      set_icon(lcdsb_pkg::ICON_FAN1, 1'b0);
      set_icon(lcdsb_pkg::ICON_FAN2, 1'b0);
      set_icon(lcdsb_pkg::ICON_FAN3, 1'b0);
      if (n == 0) set_icon(lcdsb_pkg::ICON_FAN1, 1'b1);
      else if (n == 1) set_icon(lcdsb_pkg::ICON_FAN2, 1'b1);
      else if (n == 2) set_icon(lcdsb_pkg::ICON_FAN3, 1'b1);
    end else begin
      lcd_buf[14] = (n < 7) ? 8'(1 << (n + 1)) : 8'h00;
    end
  endfunction

  function automatic void clear_fan();
    if (panel_mode == lcdsb_pkg::MODE_WHITE) draw_fan(8);
    else lcd_buf[14] = 8'h00;
  endfunction

  function automatic void show_speed(int unsigned num);
    if (panel_mode == lcdsb_pkg::MODE_WHITE) begin
      draw_digit(8, num);
    end else if (num < 10) begin
      lcd_buf[lcdsb_pkg::BLACK_PLACE[0]] &= lcdsb_pkg::BIT4;
      lcd_buf[lcdsb_pkg::BLACK_PLACE[1]] = lcdsb_pkg::GLYPH_A[lcdsb_pkg::F_GLYPH] |
                                           (lcd_buf[lcdsb_pkg::BLACK_PLACE[1]] &
                                            lcdsb_pkg::BIT4);
      lcd_buf[lcdsb_pkg::BLACK_PLACE[2]] = lcdsb_pkg::GLYPH_A[num];
      lcd_buf[lcdsb_pkg::BLACK_PLACE[3]] = 8'h00;
      lcd_buf[3] &= ~lcdsb_pkg::BIT4;
    end
  endfunction

  function automatic logic [1:0] wrap3(logic [1:0] c);
    return (c >= 2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic void advance_tick();
    blink_cnt = (blink_cnt + 4'd1 >= 4'd10) ? 4'd0 : blink_cnt + 4'd1;
    blink_on = (blink_cnt >= 3);
    if (!div2) begin
      div2 = 1'b1;
    end else begin
      div2 = 1'b0;
      cur_fast = wrap3(cur_fast);
    end
    div5 = div5 + 3'd1;
    if (div5 >= 5) begin
      div5 = '0;
      cur_slow = wrap3(cur_slow);
    end
    div3 = div3 + 2'd1;
    if (div3 >= 3) begin
      div3 = '0;
      cur_med = wrap3(cur_med);
    end
  endfunction

  function automatic lcdsb_pkg::res_t panel_status(logic [7:0] data, logic frame,
                                                   logic fin);
    lcdsb_pkg::res_t s;
    s.data_byte = data;
    s.frame_start = frame;
    s.last = fin;
    s.blink_phase = blink_on;
    s.fan_cursor_slow = cur_slow;
    s.fan_cursor_medium = cur_med;
    s.fan_cursor_fast = cur_fast;
    return s;
  endfunction

  // Apply one request to the shadow state and queue the bytes it produces
  function automatic void lcd_apply(lcdsb_pkg::req_t r);
    int unsigned idx;
    int unsigned val;
    idx = r.index;
    val = r.value;
    case (r.command)
      lcdsb_pkg::CMD_DIGIT: draw_digit(idx, val);
      lcdsb_pkg::CMD_PAIR: begin
        if (idx <= 3 && val < 100) begin
          draw_digit(2 * idx, val / 10);
          draw_digit(2 * idx + 1, val % 10);
        end
      end
      lcdsb_pkg::CMD_CLR_PAIR: begin
        if (idx <= 3) begin
          draw_digit(2 * idx, lcdsb_pkg::BLANK_GLYPH);
          draw_digit(2 * idx + 1, lcdsb_pkg::BLANK_GLYPH);
        end
      end
      lcdsb_pkg::CMD_SPEED: show_speed(val);
      lcdsb_pkg::CMD_ICON_ON: set_icon(r.index, 1'b1);
      lcdsb_pkg::CMD_ICON_OFF: set_icon(r.index, 1'b0);
      lcdsb_pkg::CMD_TOGGLE: flip_icon(r.index);
      lcdsb_pkg::CMD_FAN: draw_fan(val);
      lcdsb_pkg::CMD_CLR_FAN: clear_fan();
      lcdsb_pkg::CMD_ROTATE: begin
        if (val == 0) clear_fan();
        else if (val == 1) draw_fan(cur_slow);
        else if (val <= 3) draw_fan(cur_med);
        else draw_fan(cur_fast);
      end
      lcdsb_pkg::CMD_CLEAR:
        for (int i = lcdsb_pkg::FIRST_BYTE; i <= lcdsb_pkg::LAST_BYTE; i++)
          lcd_buf[i] = 8'h00;
      lcdsb_pkg::CMD_SET:
        for (int i = lcdsb_pkg::FIRST_BYTE; i <= lcdsb_pkg::LAST_BYTE; i++)
          lcd_buf[i] = 8'hFF;
      lcdsb_pkg::CMD_TICK: advance_tick();
      default: ;
    endcase
    if (r.command == lcdsb_pkg::CMD_FLUSH) begin
      lcd_out_q.push_back(panel_status(lcdsb_pkg::FLUSH_CMD0, 1'b1, 1'b0));
      lcd_out_q.push_back(panel_status(lcdsb_pkg::FLUSH_CMD1, 1'b1, 1'b0));
      for (int i = lcdsb_pkg::FIRST_BYTE; i <= lcdsb_pkg::LAST_BYTE; i++)
        lcd_out_q.push_back(panel_status(lcd_buf[i], 1'b0, i == lcdsb_pkg::LAST_BYTE));
    end else begin
      lcd_out_q.push_back(panel_status(8'h00, 1'b0, 1'b1));
    end
  endfunction

  function automatic void reset_shadow();
    foreach (lcd_buf[i]) lcd_buf[i] = 8'h00;
    blink_cnt = '0;
    blink_on = 1'b0;
    div2 = 1'b0;
    div3 = '0;
    div5 = '0;
    cur_slow = '0;
    cur_med = '0;
    cur_fast = '0;
    panel_mode = lcdsb_pkg::MODE_WHITE;
  endfunction

  function automatic void add_step(logic mode, logic [3:0] cmd, logic [3:0] idx,
                                   logic [7:0] val, bit typed = 1'b0,
                                   lcdsb_pkg::res_t want = '0);
    step_t s;
    s.mode = mode;
    s.r.command = cmd;
    s.r.index = idx;
    s.r.value = val;
    s.typed = typed;
    s.want = want;
    steps.push_back(s);
  endfunction

  function automatic lcdsb_pkg::req_t random_request();
    lcdsb_pkg::req_t r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) r.command = 4'($urandom_range(15, 14));
    else if (sel < 14) r.command = lcdsb_pkg::CMD_FLUSH;
    else if (sel < 30) r.command = lcdsb_pkg::CMD_TICK;
    else r.command = 4'($urandom_range(11));
    r.index = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
    case ($urandom_range(3))
      0: r.value = 8'($urandom_range(11));
      1: r.value = 8'($urandom_range(99));
      2: r.value = 8'($urandom_range(255));
      default: r.value = 8'($urandom_range(105, 95));
    endcase
    return r;
  endfunction

  // Hold start high until the block takes the request
  task automatic issue(input lcdsb_pkg::req_t r, input bit typed = 1'b0,
                       input lcdsb_pkg::res_t want = '0);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    lcd_apply(r);
    if (typed) begin
      void'(lcd_out_q.pop_back());
      lcd_out_q.push_back(want);
    end
  endtask

  task automatic drain();
    while (lcd_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_panel_mode(input logic m);
    start <= 1'b0;
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    panel_mode = m;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) flag_error($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  always @(posedge clk_i) begin : check_results
    lcdsb_pkg::res_t want;
    if (rst_ni && res_strobe_o) begin
      if (lcd_out_q.size() == 0) begin
        flag_error($sformatf("unexpected result %h", res_o));
      end else begin
        want = lcd_out_q.pop_front();
        if ($isunknown(res_o)) flag_error($sformatf("unknown bits in result %h", res_o));
        check_field("data_byte", want.data_byte, res_o.data_byte);
        check_field("frame_start", want.frame_start, res_o.frame_start);
        check_field("last", want.last, res_o.last);
        check_field("blink_phase", want.blink_phase, res_o.blink_phase);
        check_field("fan_cursor_slow", want.fan_cursor_slow, res_o.fan_cursor_slow);
        check_field("fan_cursor_medium", want.fan_cursor_medium, res_o.fan_cursor_medium);
        check_field("fan_cursor_fast", want.fan_cursor_fast, res_o.fan_cursor_fast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("[lcd_segment_buffer_controller_core] ERROR");
      $finish;
    end
  end

  initial begin
    reset_shadow();

    // Directed part; typed rows check the first ticks after reset and an unused command
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_TICK, 4'd0, 8'd0, 1'b1,
             '{8'h00, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0, 2'd0});
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_TICK, 4'd0, 8'd0, 1'b1,
             '{8'h00, 1'b0, 1'b1, 1'b0, 2'd0, 2'd0, 2'd1});
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_TICK, 4'd0, 8'd0, 1'b1,
             '{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 2'd1, 2'd1});
    add_step(lcdsb_pkg::MODE_WHITE, CMD_UNUSED, IDX_MAX, 8'd255, 1'b1,
             '{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 2'd1, 2'd1});
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_DIGIT, 4'd0, 8'd255);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_DIGIT, IDX_MAX, 8'd3);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_PAIR, 4'd3, 8'd99);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_PAIR, 4'd0, 8'd100);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_PAIR, 4'd4, 8'd12);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_CLR_PAIR, 4'd1, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_SPEED, 4'd0, 8'd7);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_ICON_ON, lcdsb_pkg::ICON_FAN3, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_ICON_ON, IDX_MAX, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_ICON_OFF, lcdsb_pkg::ICON_CLOCK, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_TOGGLE, lcdsb_pkg::ICON_LIGHT, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_FAN, 4'd0, 8'd3);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_ROTATE, 4'd0, 8'd255);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_SET, 4'd0, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_FLUSH, 4'd0, 8'd0);
    add_step(lcdsb_pkg::MODE_WHITE, lcdsb_pkg::CMD_CLEAR, 4'd0, 8'd0);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_SPEED, 4'd0, 8'd10);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_SPEED, 4'd0, 8'd9);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_FAN, 4'd0, 8'd6);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_FAN, 4'd0, 8'd7);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_ICON_ON, lcdsb_pkg::ICON_LIGHT, 8'd0);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_TOGGLE, lcdsb_pkg::ICON_COLON2, 8'd0);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_DIGIT, 4'd3, 8'd8);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_CLR_FAN, 4'd0, 8'd0);
    add_step(MODE_BLACK, lcdsb_pkg::CMD_FLUSH, 4'd0, 8'd0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_panel_mode(lcdsb_pkg::MODE_WHITE);

    foreach (steps[i]) begin
      if (steps[i].mode != panel_mode) set_panel_mode(steps[i].mode);
      issue(steps[i].r, steps[i].typed, steps[i].want);
    end

    // Random phases: mode and sender gaps change at each boundary
    for (int ph = 0; ph < 4; ph++) begin
      set_panel_mode(ph[0] ? MODE_BLACK : lcdsb_pkg::MODE_WHITE);
      case (ph)
        1: gap_pct = 58;
        2: gap_pct = 21;
        default: gap_pct = 0;
      endcase
      repeat (RANDOM_PER_PHASE) issue(random_request());
    end

    start <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lcd_out_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", lcd_out_q.size()));
    if (err_count == 0) begin
      $display("[lcd_segment_buffer_controller_core] OK");
    end else begin
      $display("[lcd_segment_buffer_controller_core] ERROR");
    end
    $finish;
  end

endmodule
